[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

[rtl/atq_pkg.sv]
// ---------------------------------------------------------------------------
// atq_pkg
// Types, constants and the divider step function of the tilt quaternion pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package atq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int FIELD_W   = 16;
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int MAG_W     = FRAC_BITS + 1;
    localparam int ROOT_W    = FRAC_BITS + 1;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int REM_W     = ROOT_W + 3;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int D_W       = ROOT_W + 1;
    localparam int NUM_W     = MAG_W + FRAC_BITS;
    localparam int LAM_MIN   = 11585;

    typedef struct packed {
        logic signed [FIELD_W-1:0] accel_x;
        logic signed [FIELD_W-1:0] accel_y;
        logic signed [FIELD_W-1:0] accel_z;
    } accel_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] quat_scalar;
        logic signed [FIELD_W-1:0] quat_x;
        logic signed [FIELD_W-1:0] quat_y;
        logic signed [FIELD_W-1:0] quat_z;
    } quat_t;

    typedef struct packed {
        logic             neg_z;
        logic             x_neg;
        logic             y_neg;
        logic [MAG_W-1:0] x_mag;
        logic [MAG_W-1:0] y_mag;
    } side_t;

    typedef struct packed {
        logic              valid;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        side_t             side;
    } sq_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [D_W-1:0]   rmd;
        logic [Q_W-1:0]   quo;
    } lane_t;

    typedef struct packed {
        logic              valid;
        logic [D_W-1:0]    dvs;
        logic [ROOT_W-1:0] lam;
        lane_t             lx;
        lane_t             ly;
        side_t             side;
    } dv_t;

    function automatic lane_t div_step(lane_t a, logic [D_W-1:0] d, logic [Q_W-1:0] bit_sel);
        logic [D_W:0] sh;
        logic [D_W:0] diff;
        lane_t        r;
        r    = a;
        sh   = {a.rmd, |(a.num[Q_W-1:0] & bit_sel)};
        diff = sh - {1'b0, d};
        if (!diff[D_W])
        begin
            r.rmd = diff[D_W-1:0];
            r.quo = {a.quo[Q_W-2:0], 1'b1};
        end
        else
        begin
            r.rmd = sh[D_W-1:0];
            r.quo = {a.quo[Q_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[rtl/atq_sqrt_cell.sv]
// ---------------------------------------------------------------------------
// atq_sqrt_cell
// One root bit of the digit-by-digit square root; passes the item on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module atq_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  atq_pkg::sq_t   cell_in,
    output atq_pkg::sq_t   cell_out
);

    logic                          valid_reg;
    atq_pkg::sq_t                  data_reg;
    atq_pkg::sq_t                  data_next;
    logic [1:0]                    pair;
    logic [atq_pkg::REM_W-1:0]     rem_sh;
    logic [atq_pkg::REM_W-1:0]     trial;

    always_comb
    begin
        pair      = cell_in.rad[atq_pkg::RAD_W-1-2*STEP -: 2];
        rem_sh    = {cell_in.rem[atq_pkg::REM_W-3:0], pair};
        trial     = {1'b0, cell_in.root, 2'b01};
        data_next = cell_in;
        if (rem_sh >= trial)
        begin
            data_next.rem  = rem_sh - trial;
            data_next.root = {cell_in.root[atq_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_sh;
            data_next.root = {cell_in.root[atq_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= cell_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    always_comb
    begin
        cell_out       = data_reg;
        cell_out.valid = valid_reg;
    end

endmodule

[rtl/atq_div_cell.sv]
// ---------------------------------------------------------------------------
// atq_div_cell
// One quotient bit of both restoring dividers; passes the item on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module atq_div_cell #(
    parameter int STEP = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  atq_pkg::dv_t   cell_in,
    output atq_pkg::dv_t   cell_out
);

    localparam logic [atq_pkg::Q_W-1:0] BIT_SEL =
        atq_pkg::Q_W'(1) << (atq_pkg::Q_W - 1 - STEP);

    logic          valid_reg;
    atq_pkg::dv_t  data_reg;
    atq_pkg::dv_t  data_next;

    always_comb
    begin
        data_next    = cell_in;
        data_next.lx = atq_pkg::div_step(cell_in.lx, cell_in.dvs, BIT_SEL);
        data_next.ly = atq_pkg::div_step(cell_in.ly, cell_in.dvs, BIT_SEL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= cell_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= data_next;
    end

    always_comb
    begin
        cell_out       = data_reg;
        cell_out.valid = valid_reg;
    end

endmodule

[rtl/accel_tilt_quaternion.sv]
// Path from accepted item to result: 15 root cells, 15 divider cells, one output
// register; the root rounding sits in front of the first divider cell.
// Throughput: one item per cycle; the whole cell chain advances together and
// holds while a result waits at the output.
// Reset: rst_n clears every stage valid bit; data registers are not reset.
// ---------------------------------------------------------------------------
// accel_tilt_quaternion
// Tilt quaternion from a normalised accelerometer sample, chain of cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module accel_tilt_quaternion (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  atq_pkg::accel_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output atq_pkg::quat_t    out_item
);

    localparam int FW = atq_pkg::FIELD_W;
    localparam logic signed [FW-1:0] ONE_S = FW'(atq_pkg::ONE);

    logic                        adv;
    logic                        out_valid_reg;
    atq_pkg::quat_t              out_reg;
    atq_pkg::quat_t              out_next;
    atq_pkg::sq_t                sq_chain [0:atq_pkg::SQ_STEPS];
    atq_pkg::dv_t                dv_chain [0:atq_pkg::Q_W];
    logic signed [FW-1:0]        cx;
    logic signed [FW-1:0]        cy;
    logic signed [FW-1:0]        cz;
    logic [FW-1:0]               zmag;
    logic [FW-1:0]               rad_base;
    logic [atq_pkg::ROOT_W-1:0]  lam;
    logic signed [FW-1:0]        sx;
    logic signed [FW-1:0]        sy;
    logic signed [FW-1:0]        lam_s;
    logic                        tail_valid;
    logic                        lam_ok;
    logic                        scalar_ok;

    function automatic logic signed [FW-1:0] clamp(logic signed [FW-1:0] v);
        if (v > ONE_S)
            return ONE_S;
        else if (v < -ONE_S)
            return -ONE_S;
        return v;
    endfunction

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // clamp, split into sign and magnitude, form the root operand
    always_comb
    begin
        cx       = clamp(in_item.accel_x);
        cy       = clamp(in_item.accel_y);
        cz       = clamp(in_item.accel_z);
        zmag     = cz[FW-1] ? -cz : cz;
        rad_base = ONE_S + zmag;
        sq_chain[0].valid      = in_valid;
        sq_chain[0].rad        = atq_pkg::RAD_W'({rad_base, (atq_pkg::FRAC_BITS-1)'(0)});
        sq_chain[0].rem        = '0;
        sq_chain[0].root       = '0;
        sq_chain[0].side.neg_z = cz[FW-1];
        sq_chain[0].side.x_neg = cx[FW-1];
        sq_chain[0].side.y_neg = cy[FW-1];
        sq_chain[0].side.x_mag = atq_pkg::MAG_W'(cx[FW-1] ? -cx : cx);
        sq_chain[0].side.y_mag = atq_pkg::MAG_W'(cy[FW-1] ? -cy : cy);
    end

    for (genvar i = 0; i < atq_pkg::SQ_STEPS; i++)
    begin : g_sqrt
        atq_sqrt_cell #(.STEP(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .cell_in  (sq_chain[i]),
            .cell_out (sq_chain[i+1])
        );
    end

    // round the root, set up both dividends
    always_comb
    begin
        lam = sq_chain[atq_pkg::SQ_STEPS].root +
              atq_pkg::ROOT_W'(sq_chain[atq_pkg::SQ_STEPS].rem >
                               atq_pkg::REM_W'(sq_chain[atq_pkg::SQ_STEPS].root));
        dv_chain[0].valid  = sq_chain[atq_pkg::SQ_STEPS].valid;
        dv_chain[0].side   = sq_chain[atq_pkg::SQ_STEPS].side;
        dv_chain[0].lam    = lam;
        dv_chain[0].dvs    = {lam, 1'b0};
        dv_chain[0].lx.num = {dv_chain[0].side.x_mag, atq_pkg::FRAC_BITS'(0)}
                             + atq_pkg::NUM_W'(lam);
        dv_chain[0].ly.num = {dv_chain[0].side.y_mag, atq_pkg::FRAC_BITS'(0)}
                             + atq_pkg::NUM_W'(lam);
        dv_chain[0].lx.rmd = atq_pkg::D_W'(dv_chain[0].lx.num[atq_pkg::NUM_W-1:atq_pkg::Q_W]);
        dv_chain[0].ly.rmd = atq_pkg::D_W'(dv_chain[0].ly.num[atq_pkg::NUM_W-1:atq_pkg::Q_W]);
        dv_chain[0].lx.quo = '0;
        dv_chain[0].ly.quo = '0;
    end

    for (genvar i = 0; i < atq_pkg::Q_W; i++)
    begin : g_div
        atq_div_cell #(.STEP(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .cell_in  (dv_chain[i]),
            .cell_out (dv_chain[i+1])
        );
    end

    // apply signs and pick the branch
    always_comb
    begin
        sx    = dv_chain[atq_pkg::Q_W].side.x_neg ?
                -FW'(dv_chain[atq_pkg::Q_W].lx.quo) : FW'(dv_chain[atq_pkg::Q_W].lx.quo);
        sy    = dv_chain[atq_pkg::Q_W].side.y_neg ?
                -FW'(dv_chain[atq_pkg::Q_W].ly.quo) : FW'(dv_chain[atq_pkg::Q_W].ly.quo);
        lam_s = FW'(dv_chain[atq_pkg::Q_W].lam);
        if (!dv_chain[atq_pkg::Q_W].side.neg_z)
        begin
            out_next.quat_scalar = lam_s;
            out_next.quat_x      = sy;
            out_next.quat_y      = -sx;
            out_next.quat_z      = '0;
        end
        else
        begin
            out_next.quat_scalar = -sy;
            out_next.quat_x      = -lam_s;
            out_next.quat_y      = '0;
            out_next.quat_z      = -sx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_chain[atq_pkg::Q_W].valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign tail_valid = dv_chain[atq_pkg::Q_W].valid;
    assign lam_ok     = dv_chain[0].lam >= atq_pkg::ROOT_W'(atq_pkg::LAM_MIN) &&
                        dv_chain[0].lam <= atq_pkg::ROOT_W'(atq_pkg::ONE);
    assign scalar_ok  = out_reg.quat_scalar <= ONE_S && out_reg.quat_scalar >= -ONE_S;

    `ASSERT_NEXT(a_out_load, adv && tail_valid, out_valid_reg, "item lost at output")
    `ASSERT_ALWAYS(a_lam_range, !dv_chain[0].valid || lam_ok, "root out of range")
    `ASSERT_ALWAYS(a_out_range, !out_valid_reg || scalar_ok, "scalar out of range")

endmodule
